@@ hw/rtl/psd_pkg.sv @@
// psd_pkg: shared sizes, payload structs, register codes and state type
// for the pairwise squared distance block; no dependencies
`default_nettype none

package psd_pkg;

  // sizing
  localparam int ROWS_MAX = 64;
  localparam int DIMS_MAX = 1024;

  localparam int ROW_W  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int CNT_W  = $clog2(ROWS_MAX + 1);
  localparam int DIM_W  = (DIMS_MAX > 1) ? $clog2(DIMS_MAX) : 1;
  localparam int RS_DEPTH = ROWS_MAX * DIMS_MAX;
  localparam int RS_AW  = (RS_DEPTH > 1) ? $clog2(RS_DEPTH) : 1;

  // fixed field widths
  localparam int ELEM_W      = 8;
  localparam int IDX_W       = 6;
  localparam int DIST_W      = 26;
  localparam int PS_W        = 27;
  localparam int SQ_W        = 2 * ELEM_W;
  localparam int DIMS_CFG_W  = 11;
  localparam int ROWS_CFG_W  = 7;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = DIMS_CFG_W;

  localparam logic [PS_W-1:0] DIST_MAX = PS_W'({DIST_W{1'b1}});

  // register reset values
  localparam logic [DIMS_CFG_W-1:0] DIMS_RESET = DIMS_CFG_W'(784);
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(64);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIMS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(1);

  typedef struct packed {
    logic [ELEM_W-1:0] element_value;
    logic              start_set;
  } in_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [DIST_W-1:0] distance;
    logic              last;
  } out_req_t;

  // operands that the sequencer hands to the accumulate unit
  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic              first;
  } mac_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_EMIT
  } state_t;

  // flat address of one element in the row store
  function automatic logic [RS_AW-1:0] rs_addr(input logic [ROW_W-1:0] row,
                                               input logic [DIM_W-1:0] pos);
    logic [RS_AW-1:0] base;
    base = RS_AW'(row) * RS_AW'(DIMS_MAX);
    return RS_AW'(base + RS_AW'(pos));
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/psd_ram.sv @@
// psd_ram: generic single-write, single-read synchronous ram
// read data registered, updated only on read enable; no dependencies
`default_nettype none

module psd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/psd_mac.sv @@
// psd_mac: squared difference plus accumulate with saturation
// depends on psd_pkg
`default_nettype none

module psd_mac (
  input  wire psd_pkg::mac_req_t                 req,
  input  wire logic [psd_pkg::ELEM_W-1:0]        other,
  input  wire logic [psd_pkg::PS_W-1:0]          old_sum,
  output logic      [psd_pkg::PS_W-1:0]          new_sum
);

  logic [psd_pkg::ELEM_W-1:0] diff;
  logic [psd_pkg::SQ_W-1:0]   sq;
  logic [psd_pkg::PS_W-1:0]   base;
  logic [psd_pkg::PS_W-1:0]   sum;

  always_comb begin
    diff = (req.elem > other) ? (req.elem - other) : (other - req.elem);
    sq   = psd_pkg::SQ_W'(diff) * psd_pkg::SQ_W'(diff);
    // first element of a row starts every sum from zero
    base = req.first ? '0 : old_sum;
    sum  = base + psd_pkg::PS_W'(sq);
    new_sum = (sum > psd_pkg::DIST_MAX) ? psd_pkg::DIST_MAX : sum;
  end

endmodule

`default_nettype wire

@@ hw/rtl/psd_ctrl.sv @@
// psd_ctrl: sequencer, counters, config registers and output register
// depends on psd_pkg; drives the row store and partial sum rams
`default_nettype none

module psd_ctrl (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire psd_pkg::in_req_t                     in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output psd_pkg::out_req_t                         out_data,
  output logic                                      rs_we,
  output logic      [psd_pkg::RS_AW-1:0]            rs_waddr,
  output logic      [psd_pkg::ELEM_W-1:0]           rs_wdata,
  output logic                                      rs_re,
  output logic      [psd_pkg::RS_AW-1:0]            rs_raddr,
  output logic                                      ps_we,
  output logic      [psd_pkg::ROW_W-1:0]            ps_waddr,
  output logic                                      ps_re,
  output logic      [psd_pkg::ROW_W-1:0]            ps_raddr,
  input  wire logic [psd_pkg::PS_W-1:0]             ps_rdata,
  output psd_pkg::mac_req_t                         mac_req
);

  localparam int CMP_W = (psd_pkg::DIM_W + 1 > psd_pkg::DIMS_CFG_W) ?
                         psd_pkg::DIM_W + 1 : psd_pkg::DIMS_CFG_W;
  localparam int RW    = (psd_pkg::CNT_W > psd_pkg::ROWS_CFG_W) ?
                         psd_pkg::CNT_W : psd_pkg::ROWS_CFG_W;

  psd_pkg::state_t state_r, state_nxt;

  logic [psd_pkg::DIMS_CFG_W-1:0] dims_r;
  logic [psd_pkg::ROWS_CFG_W-1:0] rows_r;
  logic [psd_pkg::CNT_W-1:0]      row_cnt_r;
  logic [psd_pkg::DIM_W-1:0]      elem_cnt_r;
  logic [psd_pkg::ROW_W-1:0]      row_r;
  logic [psd_pkg::DIM_W-1:0]      pos_r;
  logic [psd_pkg::ELEM_W-1:0]     elem_r;
  logic                           done_row_r;
  logic [psd_pkg::CNT_W-1:0]      scan_r;
  logic                           pend_valid_r, pend_valid_nxt;
  logic [psd_pkg::ROW_W-1:0]      pend_idx_r;
  logic                           out_valid_r, out_valid_nxt;
  psd_pkg::out_req_t              out_data_r;

  logic                           accept, take, complete, in_range;
  logic [psd_pkg::CNT_W-1:0]      eff_row;
  logic [psd_pkg::DIM_W-1:0]      eff_pos;
  logic                           scan_lt_row, scan_le_row;
  logic                           out_free, consume, issue, load_out;

  // item decode
  always_comb begin
    eff_row  = in_data.start_set ? '0 : row_cnt_r;
    eff_pos  = in_data.start_set ? '0 : elem_cnt_r;
    in_range = ((RW'(eff_row) < RW'(rows_r)) || (rows_r == '0 && eff_row == '0)) &&
               (RW'(eff_row) < RW'(psd_pkg::ROWS_MAX));
    complete = (CMP_W'(eff_pos) + CMP_W'(1) >= CMP_W'(dims_r)) ||
               (eff_pos == psd_pkg::DIM_W'(psd_pkg::DIMS_MAX - 1));
    accept   = in_valid && !in_stall;
    take     = accept && in_range;
  end

  always_comb begin
    scan_lt_row = scan_r <  psd_pkg::CNT_W'(row_r);
    scan_le_row = scan_r <= psd_pkg::CNT_W'(row_r);
    out_free    = !out_valid_r || !out_stall;
    consume     = pend_valid_r && out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      psd_pkg::ST_IDLE: begin
        if (take) begin
          state_nxt = psd_pkg::ST_ACC;
        end
      end
      psd_pkg::ST_ACC: begin
        if (!scan_lt_row && !pend_valid_r) begin
          state_nxt = done_row_r ? psd_pkg::ST_EMIT : psd_pkg::ST_IDLE;
        end
      end
      psd_pkg::ST_EMIT: begin
        if (!scan_le_row && (!pend_valid_r || consume)) begin
          state_nxt = psd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = psd_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall = 1'b1;
    issue    = 1'b0;
    ps_we    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      psd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      psd_pkg::ST_ACC: begin
        issue = scan_lt_row;
        ps_we = pend_valid_r;
      end
      psd_pkg::ST_EMIT: begin
        issue    = scan_le_row && (!pend_valid_r || consume);
        load_out = consume;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    pend_valid_nxt = issue ||
                     (pend_valid_r && state_r == psd_pkg::ST_EMIT && !consume);
    out_valid_nxt  = load_out || (out_valid_r && out_stall);
  end

  // ram and unit hookup
  always_comb begin
    rs_we    = take;
    rs_waddr = psd_pkg::rs_addr(psd_pkg::ROW_W'(eff_row), eff_pos);
    rs_wdata = in_data.element_value;
    rs_re    = issue && state_r == psd_pkg::ST_ACC;
    rs_raddr = psd_pkg::rs_addr(psd_pkg::ROW_W'(scan_r), pos_r);
    ps_re    = issue;
    ps_raddr = psd_pkg::ROW_W'(scan_r);
    ps_waddr = pend_idx_r;
    mac_req.elem  = elem_r;
    mac_req.first = (pos_r == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= psd_pkg::ST_IDLE;
      dims_r       <= psd_pkg::DIMS_RESET;
      rows_r       <= psd_pkg::ROWS_RESET;
      row_cnt_r    <= '0;
      elem_cnt_r   <= '0;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          psd_pkg::REG_DIMS: dims_r <= cfg_wdata[psd_pkg::DIMS_CFG_W-1:0];
          psd_pkg::REG_ROWS: rows_r <= cfg_wdata[psd_pkg::ROWS_CFG_W-1:0];
          default: ;
        endcase
      end
      if (take) begin
        if (complete) begin
          row_cnt_r  <= psd_pkg::CNT_W'(eff_row + psd_pkg::CNT_W'(1));
          elem_cnt_r <= '0;
        end else begin
          row_cnt_r  <= eff_row;
          elem_cnt_r <= psd_pkg::DIM_W'(eff_pos + psd_pkg::DIM_W'(1));
        end
      end
      if (take || (state_r == psd_pkg::ST_ACC && state_nxt != psd_pkg::ST_ACC)) begin
        scan_r <= '0;
      end else if (issue) begin
        scan_r <= psd_pkg::CNT_W'(scan_r + psd_pkg::CNT_W'(1));
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      row_r      <= psd_pkg::ROW_W'(eff_row);
      pos_r      <= eff_pos;
      elem_r     <= in_data.element_value;
      done_row_r <= complete;
    end
    if (issue) begin
      pend_idx_r <= psd_pkg::ROW_W'(scan_r);
    end
    if (load_out) begin
      out_data_r.row_index <= psd_pkg::IDX_W'(row_r);
      out_data_r.col_index <= psd_pkg::IDX_W'(pend_idx_r);
      out_data_r.distance  <= (pend_idx_r == row_r) ? '0 :
                              ps_rdata[psd_pkg::DIST_W-1:0];
      out_data_r.last      <= (pend_idx_r == row_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hw/rtl/pairwise_squared_distance.sv @@
// pairwise_squared_distance: top level, streaming lower-triangle distance matrix
// depends on psd_pkg, psd_ram, psd_mac, psd_ctrl
//
// usage
//   input channel (in_valid / in_stall / in_data) carries one 8-bit element per
//   request, row after row; start_set on a request restarts the data set at row 0.
//   output channel (out_valid / out_stall / out_data) carries, after the last
//   element of row i, the distances of row i to rows 0..i in column order; the
//   one against itself is zero and carries last.
//   cfg_we / cfg_index / cfg_wdata set dims_in_use (index 0) and rows_in_use
//   (index 1); write them only while the block is idle.
// sequencing
//   an element of row i > 0 makes one read of the partial sum ram and the row
//   store per earlier row, then a writeback slot, a drain step and a return to
//   idle; an element of row 0 skips the walk. the single read port of the
//   partial sum ram paces the walk; no new element enters before idle. a
//   row's results then stream out one per cycle while out_stall is low.
// reset and stall
//   rst_n clears the counters, the sequencer and the output valid flag and loads
//   dims_in_use = 784, rows_in_use = 64; the rams are not cleared (row sums
//   restart from zero at each row's first element). a stalled result holds in
//   the output register and result delivery pauses; the block takes the next
//   element as soon as the last result of a row sits in the output register.
`default_nettype none

module pairwise_squared_distance (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [psd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [psd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire psd_pkg::in_req_t                 in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output psd_pkg::out_req_t                     out_data
);

  // row store ram signals
  logic                          rs_we;
  logic [psd_pkg::RS_AW-1:0]     rs_waddr;
  logic [psd_pkg::ELEM_W-1:0]    rs_wdata;
  logic                          rs_re;
  logic [psd_pkg::RS_AW-1:0]     rs_raddr;
  logic [psd_pkg::ELEM_W-1:0]    rs_rdata;

  // partial sum ram signals
  logic                          ps_we;
  logic [psd_pkg::ROW_W-1:0]     ps_waddr;
  logic [psd_pkg::PS_W-1:0]      ps_wdata;
  logic                          ps_re;
  logic [psd_pkg::ROW_W-1:0]     ps_raddr;
  logic [psd_pkg::PS_W-1:0]      ps_rdata;

  psd_pkg::mac_req_t             mac_req;

  // sequencer: walks earlier rows for each element, then streams results after a row's last element
  psd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .rs_we     (rs_we),
    .rs_waddr  (rs_waddr),
    .rs_wdata  (rs_wdata),
    .rs_re     (rs_re),
    .rs_raddr  (rs_raddr),
    .ps_we     (ps_we),
    .ps_waddr  (ps_waddr),
    .ps_re     (ps_re),
    .ps_raddr  (ps_raddr),
    .ps_rdata  (ps_rdata),
    .mac_req   (mac_req)
  );

  // every element of every row, indexed row * DIMS_MAX + position
  psd_ram #(
    .WIDTH (psd_pkg::ELEM_W),
    .DEPTH (psd_pkg::RS_DEPTH)
  ) u_row_store (
    .clk   (clk),
    .we    (rs_we),
    .waddr (rs_waddr),
    .wdata (rs_wdata),
    .re    (rs_re),
    .raddr (rs_raddr),
    .rdata (rs_rdata)
  );

  // one running sum per earlier row; read, then update and write back the next cycle
  psd_ram #(
    .WIDTH (psd_pkg::PS_W),
    .DEPTH (psd_pkg::ROWS_MAX)
  ) u_partial_sums (
    .clk   (clk),
    .we    (ps_we),
    .waddr (ps_waddr),
    .wdata (ps_wdata),
    .re    (ps_re),
    .raddr (ps_raddr),
    .rdata (ps_rdata)
  );

  // squared difference of the new element against the stored one
  psd_mac u_mac (
    .req     (mac_req),
    .other   (rs_rdata),
    .old_sum (ps_rdata),
    .new_sum (ps_wdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/psd_checker.sv @@
// psd_checker: port-level assertions for the pairwise squared distance block
// depends on psd_pkg; bound to pairwise_squared_distance below
`default_nettype none

module psd_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_stall,
  input  wire logic                             out_valid,
  input  wire logic                             out_stall,
  input  wire psd_pkg::out_req_t                out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // no new element while a row's results are still in flight
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> in_stall)
    else $error("input taken during result delivery");

  // last result is the diagonal, others lie below it
  a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |-> out_data.row_index == out_data.col_index &&
                                   out_data.distance == '0)
    else $error("last result not on diagonal");

  a_lower_tri: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.col_index < out_data.row_index)
    else $error("result above diagonal");

  // back-to-back results of one row step the column by one
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_data.last) ##1 out_valid |->
      out_data.col_index ==
        psd_pkg::IDX_W'($past(out_data.col_index) + psd_pkg::IDX_W'(1)))
    else $error("column order broken");

endmodule

bind pairwise_squared_distance psd_checker u_psd_checker (.*);

`default_nettype wire
